// ===== sv/smpq_pkg.sv =====
// Package for the sorted min-priority queue.
// Holds sizes, opcode and status codes, and the controller/datapath structs.
// Depends on nothing.
package smpq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COUNT_W  = 7;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic load_in;
    logic ram_we;
    logic wr_value;
    logic rd_prev;
    logic idx_dec;
    logic push_commit;
    logic pop_commit;
    logic head_cap;
    logic out_load;
  } smpq_cmd_t;

  typedef struct packed {
    logic push_ok;
    logic pop_ok;
    logic idx_zero;
    logic entry_ge;
    logic out_free;
  } smpq_stat_t;

endpackage

// ===== sv/smpq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the queue's entry store; depends on nothing.
module smpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/smpq_ctrl.sv =====
// Controller state machine of the sorted min-priority queue.
// Sequences insertion shifts, pops and head reads; depends on smpq_pkg.
module smpq_ctrl import smpq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  smpq_stat_t stat,
  output smpq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_OUT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_HEAD_RD;
        end
      end
      S_POP: begin
        cmd.pop_commit = 1'b1;
        state_next     = S_HEAD_RD;
      end
      S_PUSH_RD: begin
        if (stat.idx_zero) begin
          cmd.ram_we      = 1'b1;
          cmd.wr_value    = 1'b1;
          cmd.push_commit = 1'b1;
          state_next      = S_HEAD_RD;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        cmd.ram_we = 1'b1;
        if (stat.entry_ge) begin
          cmd.idx_dec = 1'b1;
          state_next  = S_PUSH_RD;
        end else begin
          cmd.wr_value    = 1'b1;
          cmd.push_commit = 1'b1;
          state_next      = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        state_next = S_HEAD_WAIT;
      end
      S_HEAD_WAIT: begin
        cmd.head_cap = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else if (state == S_IDLE && in_valid) begin
      if (stat.push_ok) begin
        state <= S_PUSH_RD;
      end else if (stat.pop_ok) begin
        state <= S_POP;
      end else begin
        state <= S_HEAD_RD;
      end
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/smpq_datapath.sv =====
// Datapath of the sorted min-priority queue: ring-buffer pointers, entry RAM,
// compare unit and output register. Depends on smpq_pkg and smpq_ram.
module smpq_datapath import smpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         in_opcode,
  input  logic [DATA_W-1:0]  in_value,
  input  smpq_cmd_t          cmd,
  output smpq_stat_t         stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  out_head_value,
  output logic               out_head_valid,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_empty,
  output logic [1:0]         out_status
);

  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_prev;
  logic [DATA_W-1:0] value;
  logic [1:0]        status;
  logic [DATA_W-1:0] head_value;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] rd_data;
  logic              is_full;
  logic              is_empty;

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (ADDR_W+1)'(CAPACITY)) begin
      sum = sum - (ADDR_W+1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign is_full  = (cnt == CNT_W'(CAPACITY));
  assign is_empty = (cnt == '0);
  assign idx_prev = idx - CNT_W'(1);

  assign we      = cmd.ram_we;
  assign wr_addr = ring_addr(head, idx[ADDR_W-1:0]);
  assign wr_data = cmd.wr_value ? value : rd_data;
  assign rd_addr = cmd.rd_prev ? ring_addr(head, idx_prev[ADDR_W-1:0]) : head;

  assign stat.push_ok  = (in_opcode == OP_PUSH) && !is_full;
  assign stat.pop_ok   = (in_opcode == OP_POP) && !is_empty;
  assign stat.idx_zero = (idx == '0);
  assign stat.entry_ge = ($signed(rd_data) >= $signed(value));
  assign stat.out_free = !out_valid || out_ready;

  smpq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push_commit) begin
        cnt <= cnt + CNT_W'(1);
      end else if (cmd.pop_commit) begin
        cnt  <= cnt - CNT_W'(1);
        head <= ring_addr(head, ADDR_W'(1));
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      value <= in_value;
      idx   <= cnt;
      if (in_opcode == OP_PUSH && is_full) begin
        status <= ST_FULL;
      end else if (in_opcode == OP_POP && is_empty) begin
        status <= ST_POP_EMPTY;
      end else begin
        status <= ST_OK;
      end
    end else if (cmd.idx_dec) begin
      idx <= idx_prev;
    end
    if (cmd.head_cap) begin
      head_value <= rd_data;
    end
    if (cmd.out_load) begin
      out_head_value <= is_empty ? '0 : head_value;
      out_head_valid <= !is_empty;
      out_count      <= COUNT_W'(cnt);
      out_empty      <= is_empty;
      out_status     <= status;
    end
  end

endmodule

// ===== sv/sorted_min_priority_queue.sv =====
// Top level of the sorted min-priority queue.
// Joins smpq_ctrl and smpq_datapath; depends on smpq_pkg.
//
// Each input transaction on the s_ group carries an opcode in s_tuser
// (push, pop or query) and a signed 32-bit value in s_tdata. Each one
// produces exactly one output transaction on the m_ group with the smallest
// stored value, a head-valid flag, the entry count, an empty flag and a
// status code (ok, pop on empty queue, push dropped because full).
// Entries sit in one RAM as an ascending ring, so a pop only moves the head.
// A query, an unused opcode, a dropped push or a pop on an empty queue goes
// from acceptance to the head read, head capture and output register; a pop
// first moves the head. A push walks down from the tail, reading each entry
// through the RAM's registered read and shifting it up while it is greater
// than or equal to the new value, then writes the new value into the freed
// slot. One transaction is worked on at a time; the next input is accepted
// in the cycle after the result loads.
// Reset empties the queue and clears the output valid; the RAM needs no
// clearing pass. When the receiver stalls, the block holds the next result
// until the output register frees and accepts nothing more meanwhile.
module sorted_min_priority_queue import smpq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // head_value[31:0], head_valid[32], count[39:33],
                                 // empty_res[40], status[42:41], zero fill [47:43]
);

  smpq_cmd_t          cmd;
  smpq_stat_t         stat;
  logic [DATA_W-1:0]  head_value;
  logic               head_valid;
  logic [COUNT_W-1:0] count;
  logic               empty_res;
  logic [1:0]         status;

  smpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  smpq_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_opcode      (s_tuser),
    .in_value       (s_tdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_head_value (head_value),
    .out_head_valid (head_valid),
    .out_count      (count),
    .out_empty      (empty_res),
    .out_status     (status)
  );

  assign m_tdata = {5'd0, status, empty_res, count, head_valid, head_value};

endmodule

// ===== sv/smpq_checker.sv =====
// Port-level checker for the sorted min-priority queue, bound to the top level.
// Depends on smpq_pkg and sorted_min_priority_queue.
module smpq_checker import smpq_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result changed or was dropped.");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[32] != m_tdata[40])
    else $error("Head-valid and empty flags disagree.");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[40] |-> m_tdata[31:0] == 32'd0 && m_tdata[39:33] == 7'd0)
    else $error("Empty queue shows a head value or a count.");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[42:41] == ST_POP_EMPTY |-> m_tdata[40])
    else $error("Pop-on-empty status with a non-empty queue.");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[42:41] == ST_FULL |-> m_tdata[39:33] == COUNT_W'(CAPACITY))
    else $error("Push dropped while the queue was not full.");

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (.*);
